### hw/rtl/icmpf_pkg.sv
// Shared types, constants and constant functions for the ICMP echo request frame builder.
// No dependencies; imported by icmpf_csum_pipe and the core.
package icmpf_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam int HDR_BYTES         = 42;
  localparam int IP_BASE_LEN       = 28;
  localparam int IDX_W             = 6;
  localparam int CFG_W             = 48;
  localparam int CFG_IDX_W         = 2;
  localparam int ALPHA_LEN         = 26;
  localparam int PAYLOAD_WORD0     = 21;

  localparam logic [15:0] ETHERTYPE_IPV4      = 16'h0800;
  localparam logic [15:0] IP_VER_IHL_TOS      = 16'h4500;
  localparam logic [15:0] IP_IDENT            = 16'h1234;
  localparam logic [15:0] IP_FLAGS_DF         = 16'h4000;
  localparam logic [7:0]  ICMP_PROTO_NUM      = 8'd1;
  localparam logic [15:0] ICMP_ECHO_TYPE_CODE = 16'h0800;
  localparam logic [7:0]  CHAR_A              = 8'h41;

  localparam logic [47:0] SOURCE_MAC_RST   = 48'h0;
  localparam logic [47:0] NEXT_HOP_MAC_RST = 48'h52550A000202;
  localparam logic [31:0] SOURCE_IP_RST    = 32'h0A000202;
  localparam logic [7:0]  TTL_RST          = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_MAC   = 2'd0,
    REG_NEXT_HOP_MAC = 2'd1,
    REG_SOURCE_IP    = 2'd2,
    REG_TTL          = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
  } request_t;

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [15:0] ip_csum;
    logic [15:0] icmp_csum;
  } frame_fields_t;

  function automatic logic [7:0] payload_byte(int pb, int i);
    if (i >= pb) return 8'h00;
    return 8'(int'(CHAR_A) + i % ALPHA_LEN);
  endfunction

  function automatic logic [15:0] payload_word(int pb, int j);
    return {payload_byte(pb, 2 * j), payload_byte(pb, 2 * j + 1)};
  endfunction

  function automatic logic [15:0] fold_const(int s);
    int t;
    t = s;
    for (int k = 0; k < 4; k++) t = (t & 32'hFFFF) + (t >> 16);
    return 16'(t);
  endfunction

  // constant part of the IPv4 header sum (protocol byte included)
  function automatic logic [15:0] ip_const_sum(int pb);
    return fold_const(int'(IP_VER_IHL_TOS) + IP_BASE_LEN + pb + int'(IP_IDENT)
                      + int'(IP_FLAGS_DF) + int'(ICMP_PROTO_NUM));
  endfunction

  // constant part of the ICMP sum: type/code plus the whole payload
  function automatic logic [15:0] icmp_const_sum(int pb);
    int s;
    s = int'(ICMP_ECHO_TYPE_CODE);
    for (int j = 0; j < ((pb + 1) >> 1); j++) s = s + int'(payload_word(pb, j));
    return fold_const(s);
  endfunction

endpackage

### hw/rtl/icmpf_csum_pipe.sv
// Three-stage checksum pipeline: sums, first fold, second fold and complement.
// Depends on icmpf_pkg.
module icmpf_csum_pipe
  import icmpf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  request_t      req,
  input  logic [31:0]   source_ip,
  input  logic [7:0]    time_to_live,
  output logic          out_valid,
  input  logic          out_ready,
  output frame_fields_t frame
);

  localparam logic [15:0] IP_K   = ip_const_sum(PAYLOAD_BYTES);
  localparam logic [15:0] ICMP_K = icmp_const_sum(PAYLOAD_BYTES);

  logic        v1, v2, v3;
  logic        en1, en2, en3;
  request_t    r1, r2, r3;
  logic [18:0] ip1;
  logic [17:0] ic1;
  logic [16:0] ip2, ic2;
  logic [15:0] ip_fold, ic_fold;
  logic [15:0] ip3, ic3;
  logic [18:0] ip_sum;
  logic [17:0] ic_sum;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign ip_sum = 19'(IP_K) + 19'({time_to_live, 8'h00}) + 19'(source_ip[31:16])
                + 19'(source_ip[15:0]) + 19'(req.dest_addr[31:16])
                + 19'(req.dest_addr[15:0]);
  assign ic_sum = 18'(ICMP_K) + 18'(req.echo_id) + 18'(req.echo_seq);

  // after the first fold a carry leaves at most 7 in the low half, so no carry remains
  assign ip_fold = ip2[15:0] + 16'(ip2[16]);
  assign ic_fold = ic2[15:0] + 16'(ic2[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      r1  <= req;
      ip1 <= ip_sum;
      ic1 <= ic_sum;
    end
    if (en2) begin
      r2  <= r1;
      ip2 <= {1'b0, ip1[15:0]} + 17'(ip1[18:16]);
      ic2 <= {1'b0, ic1[15:0]} + 17'(ic1[17:16]);
    end
    if (en3) begin
      r3  <= r2;
      ip3 <= ~ip_fold;
      ic3 <= ~ic_fold;
    end
  end

  assign out_valid       = v3;
  assign frame.dest_addr = r3.dest_addr;
  assign frame.echo_id   = r3.echo_id;
  assign frame.echo_seq  = r3.echo_seq;
  assign frame.ip_csum   = ip3;
  assign frame.icmp_csum = ic3;

endmodule

### hw/rtl/icmp_echo_request_frame_builder_core.sv
// Top level of the ICMP echo request frame builder: config registers, serializer, output register.
// Depends on icmpf_pkg and icmpf_csum_pipe.
//
// Usage:
//   Request channel (in_valid/in_ready): dest_addr, echo_id, echo_seq, one transaction per frame.
//   Word channel (out_valid/out_ready): frame_word, word_index, last_word, one transaction per
//   16-bit big-endian frame word; last_word marks the final word.
//   Config port: cfg_write with cfg_index/cfg_data writes one register per cycle; write only
//   while no frame is in flight.
// Timing:
//   From request accept to word 0 when idle: three checksum stages, then the serializer loads
//   the frame, then the output register.
//   Throughput is one word per cycle while out_ready is high: a frame is (43 + PAYLOAD_BYTES) / 2
//   words, 37 at the default, and the rate is set by the single word-wide output port. Up to three
//   requests queue in the checksum stages behind the frame being sent.
// Reset: pipeline and output are emptied and the registers take their default values.
// Stall: a low out_ready holds the output word; the serializer and the checksum stages back up
//   in turn and in_ready drops once all stages are full. Nothing is dropped or repeated.
module icmp_echo_request_frame_builder_core
  import icmpf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          dest_addr,
  input  logic [15:0]          echo_id,
  input  logic [15:0]          echo_seq,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          frame_word,
  output logic [IDX_W-1:0]     word_index,
  output logic                 last_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int FRAME_WORDS = (HDR_BYTES + PAYLOAD_BYTES + 1) / 2;
  localparam int PAY_WORDS   = (PAYLOAD_BYTES + 1) / 2;
  localparam int PIDX_W      = (PAY_WORDS > 1) ? $clog2(PAY_WORDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);
  localparam logic [IDX_W-1:0] PAY_BASE = IDX_W'(PAYLOAD_WORD0);
  localparam logic [15:0]      IP_LEN   = 16'(IP_BASE_LEN + PAYLOAD_BYTES);

  function automatic logic [PAY_WORDS*16-1:0] pay_table();
    logic [PAY_WORDS*16-1:0] t;
    t = '0;
    for (int j = 0; j < PAY_WORDS; j++) t[j*16 +: 16] = payload_word(PAYLOAD_BYTES, j);
    return t;
  endfunction

  localparam logic [PAY_WORDS*16-1:0] PAY_TAB = pay_table();

  logic [47:0] source_mac;
  logic [47:0] next_hop_mac;
  logic [31:0] source_ip;
  logic [7:0]  time_to_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac   <= SOURCE_MAC_RST;
      next_hop_mac <= NEXT_HOP_MAC_RST;
      source_ip    <= SOURCE_IP_RST;
      time_to_live <= TTL_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SOURCE_MAC:   source_mac   <= cfg_data[47:0];
        REG_NEXT_HOP_MAC: next_hop_mac <= cfg_data[47:0];
        REG_SOURCE_IP:    source_ip    <= cfg_data[31:0];
        REG_TTL:          time_to_live <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  request_t      req;
  frame_fields_t pipe_frame;
  logic          pipe_valid, pipe_ready;

  assign req.dest_addr = dest_addr;
  assign req.echo_id   = echo_id;
  assign req.echo_seq  = echo_seq;

  icmpf_csum_pipe #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_csum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req          (req),
    .source_ip    (source_ip),
    .time_to_live (time_to_live),
    .out_valid    (pipe_valid),
    .out_ready    (pipe_ready),
    .frame        (pipe_frame)
  );

  // serializer
  logic              busy;
  logic [IDX_W-1:0]  cnt;
  frame_fields_t     frm;
  logic              out_ld, done;
  logic [15:0]       word;
  logic [PIDX_W-1:0] pidx;
  logic [IDX_W-1:0]  pofs;

  assign out_ld     = busy && (!out_valid || out_ready);
  assign done       = out_ld && (cnt == LAST_IDX);
  assign pipe_ready = !busy || done;
  assign pofs       = cnt - PAY_BASE;
  assign pidx       = PIDX_W'(pofs);

  always_comb begin
    case (cnt)
      6'd0:    word = next_hop_mac[47:32];
      6'd1:    word = next_hop_mac[31:16];
      6'd2:    word = next_hop_mac[15:0];
      6'd3:    word = source_mac[47:32];
      6'd4:    word = source_mac[31:16];
      6'd5:    word = source_mac[15:0];
      6'd6:    word = ETHERTYPE_IPV4;
      6'd7:    word = IP_VER_IHL_TOS;
      6'd8:    word = IP_LEN;
      6'd9:    word = IP_IDENT;
      6'd10:   word = IP_FLAGS_DF;
      6'd11:   word = {time_to_live, ICMP_PROTO_NUM};
      6'd12:   word = frm.ip_csum;
      6'd13:   word = source_ip[31:16];
      6'd14:   word = source_ip[15:0];
      6'd15:   word = frm.dest_addr[31:16];
      6'd16:   word = frm.dest_addr[15:0];
      6'd17:   word = ICMP_ECHO_TYPE_CODE;
      6'd18:   word = frm.icmp_csum;
      6'd19:   word = frm.echo_id;
      6'd20:   word = frm.echo_seq;
      default: word = PAY_TAB[pidx*16 +: 16];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pipe_ready) begin
        busy <= pipe_valid;
        cnt  <= '0;
      end else if (out_ld) begin
        cnt <= cnt + 6'd1;
      end
      if (out_ld)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready) frm <= pipe_frame;
    if (out_ld) begin
      frame_word <= word;
      word_index <= cnt;
      last_word  <= (cnt == LAST_IDX);
    end
  end

  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == LAST_IDX)))
    else $error("last_word does not match word_index");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == $past(word_index) + 6'd1))
    else $error("word sequence gap inside a frame");

  a_next_frame_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word && busy |=> out_valid && (word_index == '0))
    else $error("queued frame did not start at word 0");

endmodule
